>>> rtl/core/cmd_pkg.sv
// Shared types and constants for the conditional 3x3 mean despeckle block.
// Holds field widths, register codes, reset values and the divide-by-nine constants.
// No dependencies.
package cmd_pkg;

    // Field and register widths
    localparam int SAMPLE_W  = 8;
    localparam int LEN_W     = 11;
    localparam int CNT_W     = 16;
    localparam int SENS_W    = 8;
    localparam int CFG_W     = 16;
    localparam int CFG_IDX_W = 2;

    // Default line buffer depth
    localparam int MAX_LINE_DEF = 1024;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SENSITIVITY = 2'd2;

    // Register reset values and geometry floors
    localparam logic [LEN_W-1:0]  LEN_RESET  = 11'd256;
    localparam logic [CNT_W-1:0]  CNT_RESET  = 16'd256;
    localparam logic [SENS_W-1:0] SENS_RESET = 8'd4;
    localparam logic [LEN_W-1:0]  LEN_MIN    = 11'd3;
    localparam logic [CNT_W-1:0]  CNT_MIN    = 16'd3;

    // Input beat kinds
    localparam logic OPC_DRAIN = 1'b1;

    // Nine-term sum and its reciprocal: floor(s / 9) == (s * 7282) >> 16 for s < 4096
    localparam int                  SUM_W      = 12;
    localparam int                  DIV9_MUL_W = 13;
    localparam logic [DIV9_MUL_W-1:0] DIV9_MUL = 13'd7282;
    localparam int                  DIV9_SHIFT = 16;

    // One window column: line above, own line, line below
    typedef struct packed {
        logic [SAMPLE_W-1:0] up;
        logic [SAMPLE_W-1:0] mid;
        logic [SAMPLE_W-1:0] down;
    } col_t;

endpackage

>>> rtl/core/cmd_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered,
// read-first output. No dependencies.
module cmd_ram #(
    parameter  int WIDTH = 8,
    parameter  int DEPTH = 1024,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write and read; a read at the written address returns the old word
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/cmd_col_cell.sv
// One column cell of the 3x3 window chain: holds a column and takes its
// neighbor's column on each shift. Depends on cmd_pkg.
module cmd_col_cell (
    input  logic          clk,
    input  logic          shift,
    input  cmd_pkg::col_t col_in,
    output cmd_pkg::col_t col_out
);
    import cmd_pkg::*;

    col_t col_reg;

    // Advance the column by one position
    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            col_reg <= col_in;
        end
    end

    assign col_out = col_reg;

endmodule

>>> rtl/core/cmd_kernel.sv
// Window kernel: nine-term mean, neighbor closeness test and result select.
// Depends on cmd_pkg.
module cmd_kernel (
    input  cmd_pkg::col_t                 lcol,
    input  cmd_pkg::col_t                 ccol,
    input  cmd_pkg::col_t                 rcol,
    input  logic [cmd_pkg::SENS_W-1:0]    sensitivity,
    input  logic                          border,
    output logic [cmd_pkg::SAMPLE_W-1:0]  result
);
    import cmd_pkg::*;

    logic [SUM_W-1:0]            sum;
    logic [SUM_W+DIV9_MUL_W-1:0] prod;
    logic [SAMPLE_W-1:0]         mean;
    logic                        near;

    function automatic logic [SAMPLE_W-1:0] absdiff(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    // Sum the window and divide by nine through the reciprocal
    always_comb
    begin
        sum = SUM_W'(lcol.up) + SUM_W'(lcol.mid) + SUM_W'(lcol.down)
            + SUM_W'(ccol.up) + SUM_W'(ccol.mid) + SUM_W'(ccol.down)
            + SUM_W'(rcol.up) + SUM_W'(rcol.mid) + SUM_W'(rcol.down);
        prod = (SUM_W+DIV9_MUL_W)'(sum) * (SUM_W+DIV9_MUL_W)'(DIV9_MUL);
        mean = prod[DIV9_SHIFT +: SAMPLE_W];
    end

    // Compare the edge neighbors (up, left, right, down) with the raw center
    always_comb
    begin
        near = (absdiff(ccol.up, ccol.mid) <= sensitivity)
            || (absdiff(lcol.mid, ccol.mid) <= sensitivity)
            || (absdiff(rcol.mid, ccol.mid) <= sensitivity)
            || (absdiff(ccol.down, ccol.mid) <= sensitivity);
        result = (!border && near) ? mean : ccol.mid;
    end

endmodule

>>> rtl/core/conditional_mean_despeckle_3x3_top.sv
// Top level of the conditional 3x3 mean despeckle filter.
// Depends on cmd_pkg, cmd_ram, cmd_col_cell and cmd_kernel.
//
// Usage:
//   Input beats (s_*) carry one raw 8-bit sample each, or a drain beat
//   (s_tuser = 1). Each accepted beat yields exactly one output beat (m_*):
//   m_tuser flags a final sample, m_tdata carries it (or repeats the last
//   final sample when the flag is low). The final sample belongs to the
//   input one line plus one sample earlier; after the last line, line_length
//   + 1 drain beats flush the frame and end it.
//   Throughput is one beat per cycle while the receiver keeps up. The line
//   buffers are read into the read stage when a beat is accepted, and the
//   window kernel loads the output register when that stage moves on.
//   Two line buffers of MAX_LINE bytes (raw previous line, final values of
//   the line above) feed a chain of two window column cells plus the
//   incoming column; the kernel result is written back into the left cell.
//   When the receiver stalls, one beat waits in the output register and one
//   in the read stage; the input is then held off via s_tready.
//   Reset clears counters, pipeline valids and the registers to their
//   defaults; line buffer contents are not cleared and need no clearing.
//   Configuration is written through cfg_write/cfg_index/cfg_data while idle;
//   a line_length or line_count write restarts the frame.
module conditional_mean_despeckle_3x3_top #(
    parameter int MAX_LINE = cmd_pkg::MAX_LINE_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [cmd_pkg::SAMPLE_W-1:0]    s_tdata,   // [7:0] sample
    input  logic [0:0]                      s_tuser,   // [0] opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [cmd_pkg::SAMPLE_W-1:0]    m_tdata,   // [7:0] filtered
    output logic [0:0]                      m_tuser,   // [0] result_valid
    input  logic                            cfg_write,
    input  logic [cmd_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [cmd_pkg::CFG_W-1:0]       cfg_data
);
    import cmd_pkg::*;

    localparam int PW = $clog2(MAX_LINE + 1);
    localparam int AW = $clog2(MAX_LINE);

    typedef struct packed {
        logic                res_valid;
        logic                active;
        logic                border;
        logic [AW-1:0]       fin_addr;
        logic [SAMPLE_W-1:0] sample;
    } stage_t;

    // Configuration registers
    logic [LEN_W-1:0]  len_cfg_reg;
    logic [CNT_W-1:0]  cnt_cfg_reg;
    logic [SENS_W-1:0] sens_reg;
    logic              geom_write;

    // Frame counters
    logic [PW-1:0]    pos_reg, pos_next;
    logic [CNT_W-1:0] li_reg, li_next;
    logic [PW-1:0]    len_eff;
    logic [CNT_W-1:0] cnt_eff;
    logic [PW:0]      pos_inc;

    // Accept stage decode
    logic          accept, act, in_frame, ignored, pos_zero;
    logic          res_valid_d, border_d;
    logic [AW-1:0] rd_addr, fin_addr_d;
    logic [PW-1:0] fin_pos;

    // Pipeline
    logic          s1_valid_reg;
    stage_t        s1_reg;
    logic          out_valid_reg;
    logic          out_adv, s1_move, res_flag;
    logic [SAMPLE_W-1:0] m_tdata_reg, last_fin_reg;
    logic          m_tuser_reg;

    // Window
    logic [SAMPLE_W-1:0] raw_rd, fin_rd, result;
    col_t          col_right, col_center, col_left, col_left_in;
    logic          cell_shift;

    // Register writes; unknown indexes drop
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_cfg_reg <= LEN_RESET;
            cnt_cfg_reg <= CNT_RESET;
            sens_reg    <= SENS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_LINE_LENGTH: len_cfg_reg <= cfg_data[LEN_W-1:0];
                REG_LINE_COUNT:  cnt_cfg_reg <= cfg_data[CNT_W-1:0];
                REG_SENSITIVITY: sens_reg    <= cfg_data[SENS_W-1:0];
                default:         ;
            endcase
        end
    end

    assign geom_write = cfg_write
        && (cfg_index == REG_LINE_LENGTH || cfg_index == REG_LINE_COUNT);

    // Clamp geometry to the supported range
    always_comb
    begin
        if (len_cfg_reg < LEN_MIN)
        begin
            len_eff = PW'(LEN_MIN);
        end
        else if (32'(len_cfg_reg) > 32'(MAX_LINE))
        begin
            len_eff = PW'(MAX_LINE);
        end
        else
        begin
            len_eff = PW'(len_cfg_reg);
        end
        cnt_eff = (cnt_cfg_reg < CNT_MIN) ? CNT_MIN : cnt_cfg_reg;
    end

    // Decode the beat at the accept stage
    always_comb
    begin
        accept   = s_tvalid && s_tready;
        in_frame = li_reg < cnt_eff;
        ignored  = in_frame && (s_tuser[0] == OPC_DRAIN);
        act      = accept && !ignored;
        pos_zero = (pos_reg == '0);
        pos_inc  = {1'b0, pos_reg} + (PW+1)'(1);

        if (pos_zero)
        begin
            res_valid_d = (li_reg[CNT_W-1:1] != '0);
            border_d    = 1'b1;
            fin_pos     = len_eff - PW'(1);
        end
        else
        begin
            res_valid_d = (li_reg != '0);
            border_d    = (li_reg == CNT_W'(1)) || !in_frame
                       || (pos_reg == PW'(1)) || (pos_reg >= len_eff);
            fin_pos     = pos_reg - PW'(1);
        end
        fin_addr_d = AW'(fin_pos);
        rd_addr    = (32'(pos_reg) >= 32'(MAX_LINE)) ? AW'(MAX_LINE - 1) : AW'(pos_reg);
    end

    // Advance the scan position; the tail wraps the frame
    always_comb
    begin
        pos_next = pos_reg;
        li_next  = li_reg;
        if (geom_write)
        begin
            pos_next = '0;
            li_next  = '0;
        end
        else if (act)
        begin
            if (in_frame)
            begin
                if (pos_inc >= {1'b0, len_eff})
                begin
                    pos_next = '0;
                    li_next  = li_reg + CNT_W'(1);
                end
                else
                begin
                    pos_next = PW'(pos_inc);
                end
            end
            else if (pos_inc > {1'b0, len_eff})
            begin
                pos_next = '0;
                li_next  = '0;
            end
            else
            begin
                pos_next = PW'(pos_inc);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            li_reg  <= '0;
        end
        else
        begin
            pos_reg <= pos_next;
            li_reg  <= li_next;
        end
    end

    // Raw samples of the previous line
    cmd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_LINE)
    ) u_raw_line (
        .clk     (clk),
        .wr_en   (act && in_frame),
        .wr_addr (rd_addr),
        .wr_data (s_tdata),
        .rd_en   (act),
        .rd_addr (rd_addr),
        .rd_data (raw_rd)
    );

    // Final samples of the line above the center
    cmd_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_LINE)
    ) u_fin_line (
        .clk     (clk),
        .wr_en   (s1_move && s1_reg.active && s1_reg.res_valid),
        .wr_addr (s1_reg.fin_addr),
        .wr_data (result),
        .rd_en   (act),
        .rd_addr (rd_addr),
        .rd_data (fin_rd)
    );

    // Handshake between the read stage and the output register
    assign out_adv  = !out_valid_reg || m_tready;
    assign s1_move  = s1_valid_reg && out_adv;
    assign s_tready = !s1_valid_reg || out_adv;

    // Hold the beat while the line buffers are read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_reg.res_valid <= res_valid_d;
            s1_reg.active    <= !ignored;
            s1_reg.border    <= border_d;
            s1_reg.fin_addr  <= fin_addr_d;
            s1_reg.sample    <= s_tdata;
        end
    end

    // Window: incoming column, center cell, left cell (takes the final value)
    assign col_right.up   = fin_rd;
    assign col_right.mid  = raw_rd;
    assign col_right.down = s1_reg.sample;
    assign cell_shift     = s1_move && s1_reg.active;

    assign col_left_in.up   = col_center.up;
    assign col_left_in.mid  = result;
    assign col_left_in.down = col_center.down;

    cmd_col_cell u_cell_center (
        .clk     (clk),
        .shift   (cell_shift),
        .col_in  (col_right),
        .col_out (col_center)
    );

    cmd_col_cell u_cell_left (
        .clk     (clk),
        .shift   (cell_shift),
        .col_in  (col_left_in),
        .col_out (col_left)
    );

    cmd_kernel u_kernel (
        .lcol        (col_left),
        .ccol        (col_center),
        .rcol        (col_right),
        .sensitivity (sens_reg),
        .border      (s1_reg.border),
        .result      (result)
    );

    assign res_flag = s1_reg.active && s1_reg.res_valid;

    // Output register; drop valid once the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            last_fin_reg  <= '0;
        end
        else if (s1_move)
        begin
            out_valid_reg <= 1'b1;
            if (res_flag)
            begin
                last_fin_reg <= result;
            end
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            m_tuser_reg <= res_flag;
            m_tdata_reg <= res_flag ? result : last_fin_reg;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

    // Counters stay within the clamped geometry
    a_line_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        li_reg <= cnt_eff)
        else $error("line index beyond line count");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= len_eff)
        else $error("position beyond line length");

    // A geometry write restarts the frame
    a_geom_restart: assert property (@(posedge clk) disable iff (!rst_n)
        geom_write |=> (pos_reg == '0) && (li_reg == '0))
        else $error("frame not restarted after geometry write");

    // A pending output beat always carries the latest final sample
    a_out_matches_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata == last_fin_reg))
        else $error("output beat differs from last final sample");

endmodule
